@@ rtl/valid_masked_moving_average_core_defines.svh @@
// ----------------------------------------------------------------------------
// valid_masked_moving_average_core_defines.svh
// Assertion macros for the moving average core.
// ----------------------------------------------------------------------------
`ifndef VALID_MASKED_MOVING_AVERAGE_CORE_DEFINES_SVH
`define VALID_MASKED_MOVING_AVERAGE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define VMA_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");

`define VMA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

`define VMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequence violated");

`else

`define VMA_ASSERT_ALWAYS(label, clk, rst, expr)
`define VMA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define VMA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/vma_pkg.sv @@
// ----------------------------------------------------------------------------
// vma_pkg
// Shared constants and types of the valid-masked moving average core.
// ----------------------------------------------------------------------------
`default_nettype none

package vma_pkg;

  localparam int DEFAULT_WINDOW_DEPTH = 16;
  localparam int SAMPLE_W             = 16;
  localparam int COUNT_OUT_W          = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } vma_state_t;

endpackage

`default_nettype wire

@@ rtl/vma_ram.sv @@
// ----------------------------------------------------------------------------
// vma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/valid_masked_moving_average_core.sv @@
// ----------------------------------------------------------------------------
// valid_masked_moving_average_core
// Mean of the valid readings among the last WINDOW_DEPTH samples.
// ----------------------------------------------------------------------------
// Input beat: sample and sample_valid on in_valid/in_ready. Output beat:
// average and valid_count on out_valid/out_ready, one output beat per input.
// Each beat replaces the oldest slot of the window; the exact sum and the
// count of valid slots are updated, then the sum is divided by the count
// with a restoring divider that produces one quotient bit per cycle.
// SUM_W is 16 + log2 of the window depth, 20 at the default depth. With
// an empty window the divide is skipped.
// in_ready is high while no item is in progress. A finished result sits in
// the output register; the next input beat is taken while it waits. If the
// receiver stalls longer than one item, the core holds the next result
// and stays busy until the output register frees up.
// Reset clears the window flags, count, sum, write pointer and output
// valid; stored readings need no clearing, since an invalid slot's reading
// is never used.
// ----------------------------------------------------------------------------
`default_nettype none

`include "valid_masked_moving_average_core_defines.svh"

module valid_masked_moving_average_core
  import vma_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                       sample_valid,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      average,
  output logic [COUNT_OUT_W-1:0]          valid_count
);

  localparam int PTR_W  = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_W + PTR_W;
  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);

  vma_state_t state, state_next;

  logic [PTR_W-1:0]         write_pointer;
  logic [WINDOW_DEPTH-1:0]  valid_flags;
  logic [CNT_W-1:0]         valid_total, total_next;
  logic [SUM_W-1:0]         running_sum, sum_next, sum_mag;
  logic [SAMPLE_W-1:0]      new_sample, old_sample;
  logic                     new_valid, old_valid;
  logic [SUM_W-1:0]         div_reg;
  logic [CNT_W-1:0]         remainder;
  logic [STEP_W-1:0]        step;
  logic                     negative;
  logic [CNT_W:0]           trial, trial_diff;
  logic                     take;
  logic [SAMPLE_W-1:0]      quotient, avg_value;
  logic [CNT_W+COUNT_OUT_W-1:0] count_wide;
  logic                     load_out;
  logic                     in_fire;

  vma_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (state == ST_UPDATE),
    .waddr(write_pointer),
    .wdata(new_sample),
    .raddr(write_pointer),
    .rdata(old_sample)
  );

  assign in_fire   = in_valid && in_ready;
  assign old_valid = valid_flags[write_pointer];

  always_comb begin
    sum_next   = running_sum;
    total_next = valid_total;
    if (old_valid) begin
      sum_next   = sum_next - {{(SUM_W - SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample};
      total_next = total_next - CNT_W'(1);
    end
    if (new_valid) begin
      sum_next   = sum_next + {{(SUM_W - SAMPLE_W){new_sample[SAMPLE_W-1]}}, new_sample};
      total_next = total_next + CNT_W'(1);
    end
    sum_mag = sum_next[SUM_W-1] ? (~sum_next + SUM_W'(1)) : sum_next;
  end

  assign trial      = {remainder, div_reg[SUM_W-1]};
  assign trial_diff = trial - {1'b0, valid_total};
  assign take       = (trial >= {1'b0, valid_total});

  assign quotient   = div_reg[SAMPLE_W-1:0];
  assign avg_value  = negative ? (~quotient + SAMPLE_W'(1)) : quotient;
  assign count_wide = {{COUNT_OUT_W{1'b0}}, valid_total};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = (total_next == '0) ? ST_DONE : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (step == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      valid_flags   <= '0;
      valid_total   <= '0;
      running_sum   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (in_fire) begin
        new_sample <= sample;
        new_valid  <= sample_valid;
      end

      if (state == ST_UPDATE) begin
        running_sum                <= sum_next;
        valid_total                <= total_next;
        valid_flags[write_pointer] <= new_valid;
        write_pointer <= (write_pointer == PTR_LAST) ? '0 : write_pointer + PTR_W'(1);
        div_reg   <= (total_next == '0) ? '0 : sum_mag;
        negative  <= (total_next != '0) && sum_next[SUM_W-1];
        remainder <= '0;
        step      <= STEP_W'(SUM_W - 1);
      end

      if (state == ST_DIVIDE) begin
        div_reg   <= {div_reg[SUM_W-2:0], take};
        remainder <= take ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
        step      <= step - STEP_W'(1);
      end

      if (load_out) begin
        out_valid   <= 1'b1;
        average     <= avg_value;
        valid_count <= count_wide[COUNT_OUT_W-1:0];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `VMA_ASSERT_ALWAYS(a_count_matches_flags, clk, rst, $countones(valid_flags) == valid_total)
  `VMA_ASSERT_IMPLY(a_rem_below_divisor, clk, rst, state == ST_DIVIDE, remainder < valid_total)
  `VMA_ASSERT_NEXT(a_divide_ends, clk, rst, state == ST_DIVIDE && step == '0, state == ST_DONE)
  `VMA_ASSERT_NEXT(a_result_loaded, clk, rst, load_out, out_valid && state == ST_IDLE)

endmodule

`default_nettype wire
